/* design/imf_pkg.sv */
// imf_pkg: shared types, register indexes and cylinder decode for the
// ignition misfire generator. No dependencies.
`timescale 1ns / 1ps

package imf_pkg;

  localparam int CUT_CYLINDERS = 4;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 16;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECURRENCE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SUCCESSIVE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DETERMINISTIC = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANDOM_RATE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET        = 3'd5;

  localparam logic [2:0] CYL_NONE = 3'd0;
  localparam logic [2:0] CYL_LAST = 3'd6;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [2:0]  cylinder;
    logic        cam_present;
    logic        phase_inhibit;
    logic        engine_synced;
    logic        phase_done;
    logic [10:0] timer_bits;
  } item_t;

  typedef struct packed {
    logic [3:0] cut_mask;
    logic       phase_ok;
    logic       armed;
    logic       cylinder_error;
  } result_t;

  typedef struct packed {
    logic        enable;
    logic [7:0]  recurrence;
    logic        successive_mode;
    logic        deterministic_mode;
    logic [15:0] random_rate;
    logic [2:0]  target_cylinder;
  } cfg_t;

  // one-hot cut bit for a cylinder; cylinders above the cut range give none
  function automatic logic [3:0] cyl_mask(input logic [2:0] cyl);
    logic [3:0] m;
    m = 4'b0000;
    if (cyl != CYL_NONE && 32'(cyl) <= CUT_CYLINDERS && cyl <= 3'd4) begin
      m = 4'b0001 << (cyl - 3'd1);
    end
    return m;
  endfunction

  function automatic logic cyl_invalid(input logic [2:0] cyl);
    return (cyl == CYL_NONE) || (cyl > CYL_LAST);
  endfunction

endpackage

/* design/ignition_misfire_generator.sv */
// ignition_misfire_generator: top level with request register, result register
// and handshake. Depends on imf_pkg, imf_cfg_regs and imf_core.
// Throughput: one request per cycle unless the result register is stalled by
// result_ready; the event logic sits between the request register and the result
// register and carries its state across requests.
// Reset (rst, synchronous): registers to defaults, all counters and flags cleared.
`timescale 1ns / 1ps

module ignition_misfire_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  imf_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output imf_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [imf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [imf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  imf_pkg::cfg_t    cfg;
  imf_pkg::item_t   item_q;
  imf_pkg::result_t res_comb;
  logic             item_full;
  logic             advance;

  assign advance    = item_full && (!result_valid || result_ready);
  assign item_ready = !item_full || advance;

  imf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  imf_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_q),
    .cfg     (cfg),
    .res     (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      item_full    <= (item_valid && item_ready) || (item_full && !advance);
      result_valid <= advance || (result_valid && !result_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
    if (advance) begin
      result <= res_comb;
    end
  end

  a_onehot_cut: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0(result.cut_mask))
    else $error("cut mask has more than one bit set");

  a_idle_no_cut: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.armed) |-> (result.cut_mask == 4'b0000 &&
                                         !result.cylinder_error))
    else $error("cut or error reported while not armed");

  a_cut_not_error: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.cut_mask != 4'b0000) |-> !result.cylinder_error)
    else $error("cut and cylinder error on the same event");

  a_request_held: assert property (@(posedge clk) disable iff (rst)
    (item_full && !advance) |=> (item_full && $stable(item_q)))
    else $error("stalled request lost from request register");

endmodule

/* design/imf_cfg_regs.sv */
// imf_cfg_regs: configuration register file of the misfire generator.
// Depends on imf_pkg.
`timescale 1ns / 1ps

module imf_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [imf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [imf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output imf_pkg::cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable             <= 1'b0;
      cfg.recurrence         <= 8'd0;
      cfg.successive_mode    <= 1'b0;
      cfg.deterministic_mode <= 1'b1;
      cfg.random_rate        <= 16'd0;
      cfg.target_cylinder    <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        imf_pkg::CFG_ENABLE:        cfg.enable             <= cfg_data[0];
        imf_pkg::CFG_RECURRENCE:    cfg.recurrence         <= cfg_data[7:0];
        imf_pkg::CFG_SUCCESSIVE:    cfg.successive_mode    <= cfg_data[0];
        imf_pkg::CFG_DETERMINISTIC: cfg.deterministic_mode <= cfg_data[0];
        imf_pkg::CFG_RANDOM_RATE:   cfg.random_rate        <= cfg_data[15:0];
        imf_pkg::CFG_TARGET:        cfg.target_cylinder    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

/* design/imf_core.sv */
// imf_core: per-event arming, spark counting and random cut decision with
// the state it carries between events. Depends on imf_pkg.
`timescale 1ns / 1ps

module imf_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  imf_pkg::item_t   item,
  input  imf_pkg::cfg_t    cfg,
  output imf_pkg::result_t res
);

  logic [7:0] spark_count, spark_count_next;
  logic armed_flag, armed_flag_next;
  logic activate_prev, inhibit_prev;
  logic low_hit_prev, low_hit_prev_next;
  logic low_hit_prev2, low_hit_prev2_next;
  logic both_hit_prev, both_hit_prev_next;

  logic       phase_ok, run, activ;
  logic [7:0] count_arm, count_inc;
  logic       armed_arm, first_succ, det_hit;
  logic       low_hit, both_hit, rnd_cut;
  logic [3:0] mask;
  logic       err;

  always_comb begin
    phase_ok = (item.cam_present && item.phase_inhibit) ? item.engine_synced
                                                          : item.phase_done;
    run   = (cfg.recurrence != 8'd0) && cfg.enable && phase_ok;
    activ = run && (item.cylinder == cfg.target_cylinder) && !armed_flag;

    count_arm = spark_count;
    armed_arm = armed_flag;
    if (run) begin
      if (activ && !activate_prev) begin
        armed_arm = 1'b1;
        count_arm = cfg.recurrence;
      end
    end else if (inhibit_prev) begin
      armed_arm = 1'b0;
      count_arm = 8'd0;
    end

    count_inc  = (count_arm == imf_pkg::COUNT_MAX) ? count_arm : count_arm + 8'd1;
    first_succ = cfg.successive_mode && (count_inc == 8'd1);
    det_hit    = (count_inc >= cfg.recurrence) || first_succ;

    // random mode: scaled timer bits against the rate
    low_hit  = {item.timer_bits, 5'd0} < cfg.random_rate;
    both_hit = low_hit && ({item.timer_bits[8:0], 7'd0} < cfg.random_rate);
    rnd_cut  = (low_hit_prev2 && low_hit_prev && low_hit) ? 1'b0
                                                          : (low_hit || both_hit_prev);

    spark_count_next   = count_arm;
    armed_flag_next    = armed_arm;
    low_hit_prev_next  = low_hit_prev;
    low_hit_prev2_next = low_hit_prev2;
    both_hit_prev_next = both_hit_prev;
    mask = 4'b0000;
    err  = 1'b0;

    if (armed_arm) begin
      if (cfg.deterministic_mode) begin
        spark_count_next = count_inc;
        if (det_hit) begin
          mask = imf_pkg::cyl_mask(item.cylinder);
          err  = imf_pkg::cyl_invalid(item.cylinder);
          if (!first_succ) begin
            spark_count_next = 8'd0;
          end
        end
      end else begin
        spark_count_next   = 8'd0;
        mask = rnd_cut ? imf_pkg::cyl_mask(item.cylinder) : 4'b0000;
        err  = imf_pkg::cyl_invalid(item.cylinder);
        low_hit_prev2_next = low_hit_prev;
        low_hit_prev_next  = low_hit;
        both_hit_prev_next = both_hit;
      end
    end

    res.cut_mask       = mask;
    res.phase_ok       = phase_ok;
    res.armed          = armed_arm;
    res.cylinder_error = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spark_count   <= 8'd0;
      armed_flag    <= 1'b0;
      activate_prev <= 1'b0;
      inhibit_prev  <= 1'b0;
      low_hit_prev  <= 1'b0;
      low_hit_prev2 <= 1'b0;
      both_hit_prev <= 1'b0;
    end else if (advance) begin
      spark_count   <= spark_count_next;
      armed_flag    <= armed_flag_next;
      activate_prev <= activ;
      inhibit_prev  <= run;
      low_hit_prev  <= low_hit_prev_next;
      low_hit_prev2 <= low_hit_prev2_next;
      both_hit_prev <= both_hit_prev_next;
    end
  end

endmodule
